FILE: design/csvtok_pkg.sv
// Shared types and constants for the CSV record tokenizer.
// Used by csvtok_step, csvtok_outbuf and csv_record_tokenizer_unit; depends on nothing.
`default_nettype none

package csvtok_pkg;

    localparam logic [15:0] CU_BOM   = 16'hFEFF;
    localparam logic [15:0] CU_QUOTE = 16'h0022;
    localparam logic [15:0] CU_COMMA = 16'h002C;
    localparam logic [15:0] CU_CR    = 16'h000D;
    localparam logic [15:0] CU_LF    = 16'h000A;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FEND = 2'd1;
    localparam logic [1:0] KIND_REND = 2'd2;

    localparam logic [1:0] QM_OUT  = 2'd0;
    localparam logic [1:0] QM_IN   = 2'd1;
    localparam logic [1:0] QM_PEND = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ch;
        logic        hdr;
        logic        empty;
        logic        last;
    } t_event;

    typedef struct packed {
        t_event     ev0;
        t_event     ev1;
        logic [1:0] cnt;
    } t_result_pair;

    typedef struct packed {
        logic [1:0] qm;
        logic       fhc;
        logic       rhd;
        logic       ropen;
        logic       after_cr;
        logic       hseen;
        logic       at_first;
    } t_state;

    localparam t_state STATE_RESET = '{
        qm: QM_OUT, fhc: 1'b0, rhd: 1'b0, ropen: 1'b0,
        after_cr: 1'b0, hseen: 1'b0, at_first: 1'b1
    };

endpackage

`default_nettype wire

FILE: design/csv_record_tokenizer_unit.sv
// Top level of the CSV record tokenizer: input register, tokenizer state and result buffer.
// Depends on csvtok_pkg, csvtok_step and csvtok_outbuf.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata = code_unit, tlast = final_unit
//   m_axis    out        tdata = char_value, is_header, all_fields_empty;
//                        tuser = event_kind, tlast = run_last
//
// A code unit is taken into the input register and processed once the result buffer can
// take its events; an item with at most one event sustains one item per cycle while the
// output does not stall. An item with two events holds the buffer until both are sent.
// Reset is synchronous and active low and returns the tokenizer to the start of content.
// A stalled output, or an item with two events, holds the input register, and the input
// side stalls only then.
`default_nettype none

module csv_record_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // final_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] char_value, [16] is_header,
                                        // [17] all_fields_empty, [23:18] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast    // run_last
);
    import csvtok_pkg::*;

    logic         r_in_valid;
    logic [15:0]  r_code;
    logic         r_final;
    t_state       r_state;
    t_state       n_state;
    t_result_pair step_res;
    logic         can_load;
    logic         fire;

    assign fire          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_code  <= s_axis_tdata;
            r_final <= s_axis_tlast;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    csvtok_step u_step (
        .i_state (r_state),
        .i_code  (r_code),
        .i_final (r_final),
        .o_state (n_state),
        .o_res   (step_res)
    );

    csvtok_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_res         (step_res),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: design/csvtok_step.sv
// Combinational tokenizer step: next state and up to two events for one code unit.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_step (
    input  csvtok_pkg::t_state       i_state,
    input  logic [15:0]              i_code,
    input  logic                     i_final,
    output csvtok_pkg::t_state       o_state,
    output csvtok_pkg::t_result_pair o_res
);
    import csvtok_pkg::*;

    t_state s;
    t_event ev_a;
    t_event ev_b;
    logic   a_vld;
    logic   b_vld;
    logic   proc;
    logic   outside;

    always_comb begin
        s       = i_state;
        ev_a    = '0;
        ev_b    = '0;
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        proc    = 1'b0;
        outside = 1'b0;
        o_res   = '0;

        s.at_first = 1'b0;
        if (!(i_state.at_first && i_code == CU_BOM)) begin
            if (s.after_cr) begin
                s.after_cr = 1'b0;
                proc       = (i_code != CU_LF);
            end else begin
                proc = 1'b1;
            end
        end

        if (proc) begin
            if (s.qm == QM_PEND) begin
                if (i_code == CU_QUOTE) begin
                    a_vld    = 1'b1;
                    ev_a.kind = KIND_CHAR;
                    ev_a.ch  = CU_QUOTE;
                    ev_a.hdr = !s.hseen;
                    s.fhc    = 1'b1;
                    s.qm     = QM_IN;
                end else begin
                    s.qm    = QM_OUT;
                    outside = 1'b1;
                end
            end else if (s.qm != QM_OUT) begin
                if (i_code == CU_QUOTE) begin
                    s.qm = QM_PEND;
                end else begin
                    a_vld     = 1'b1;
                    ev_a.kind = KIND_CHAR;
                    ev_a.ch   = i_code;
                    ev_a.hdr  = !s.hseen;
                    s.fhc     = 1'b1;
                end
            end else begin
                outside = 1'b1;
            end
        end

        if (outside && !(!s.ropen && s.hseen && (i_code == CU_CR || i_code == CU_LF))) begin
            s.ropen = 1'b1;
            if (i_code == CU_QUOTE && !s.fhc) begin
                s.qm = QM_IN;
            end else if (i_code == CU_COMMA) begin
                a_vld     = 1'b1;
                ev_a.kind = KIND_FEND;
                ev_a.hdr  = !s.hseen;
                s.rhd     = s.rhd | s.fhc;
                s.fhc     = 1'b0;
            end else if (i_code == CU_CR || i_code == CU_LF) begin
                a_vld      = 1'b1;
                ev_a.kind  = KIND_REND;
                ev_a.hdr   = !s.hseen;
                ev_a.empty = !(s.rhd | s.fhc);
                s.qm       = QM_OUT;
                s.fhc      = 1'b0;
                s.rhd      = 1'b0;
                s.ropen    = 1'b0;
                s.hseen    = 1'b1;
                if (i_code == CU_CR) begin
                    s.after_cr = 1'b1;
                end
            end else begin
                a_vld     = 1'b1;
                ev_a.kind = KIND_CHAR;
                ev_a.ch   = i_code;
                ev_a.hdr  = !s.hseen;
                s.fhc     = 1'b1;
            end
        end

        if (i_final) begin
            if (s.ropen || !s.hseen) begin
                b_vld      = 1'b1;
                ev_b.kind  = KIND_REND;
                ev_b.hdr   = !s.hseen;
                ev_b.empty = !(s.rhd | s.fhc);
            end
            s = STATE_RESET;
        end

        if (a_vld) begin
            o_res.ev0      = ev_a;
            o_res.ev0.last = !b_vld;
            o_res.ev1      = ev_b;
            o_res.ev1.last = 1'b1;
            o_res.cnt      = b_vld ? 2'd2 : 2'd1;
        end else if (b_vld) begin
            o_res.ev0      = ev_b;
            o_res.ev0.last = 1'b1;
            o_res.cnt      = 2'd1;
        end

        o_state = s;
    end

endmodule

`default_nettype wire

FILE: design/csvtok_outbuf.sv
// Two-entry result buffer that holds the events of one item and drives the output stream.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_outbuf (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  csvtok_pkg::t_result_pair i_res,
    output logic                     o_can_load,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [23:0]              m_axis_tdata,  // [15:0] char_value, [16] is_header,
                                                    // [17] all_fields_empty, [23:18] zero
    output logic [1:0]               m_axis_tuser,  // [1:0] event_kind
    output logic                     m_axis_tlast   // run_last
);
    import csvtok_pkg::*;

    t_event     r_ev0;
    t_event     r_ev1;
    logic [1:0] r_cnt;
    t_event     n_ev0;
    t_event     n_ev1;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop        = m_axis_tvalid && m_axis_tready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_comb begin
        n_ev0 = r_ev0;
        n_ev1 = r_ev1;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ev0 = i_res.ev0;
            n_ev1 = i_res.ev1;
            n_cnt = i_res.cnt;
        end else if (pop) begin
            n_ev0 = r_ev1;
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev0 <= n_ev0;
        r_ev1 <= n_ev1;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {6'd0, r_ev0.empty, r_ev0.hdr, r_ev0.ch};
    assign m_axis_tuser  = r_ev0.kind;
    assign m_axis_tlast  = r_ev0.last;

endmodule

`default_nettype wire

FILE: test/csv_record_tokenizer_unit_tb.sv
// Self-checking testbench for csv_record_tokenizer_unit: directed rows, then random CSV text.
// Expected events come from typed table rows or a bench tokenizer model, checked in order.
// Depends on csvtok_pkg and csv_record_tokenizer_unit.
module csv_record_tokenizer_unit_tb;

    import csvtok_pkg::*;

    localparam int RAND_ITEMS  = 1525;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] cu;
        logic        fin;
        logic        typed;
        logic [1:0]  n;
        t_event      e0;
        t_event      e1;
    } t_dir_row;

    localparam t_event NO_EV = '0;

    localparam t_dir_row DIR_TAB [25] = '{
        '{CU_BOM,   1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
        '{16'h0000, 1'b0, 1'b1, 2'd1, '{KIND_CHAR, 16'h0000, 1'b1, 1'b0, 1'b1}, NO_EV},
        '{16'hFFFF, 1'b0, 1'b1, 2'd1, '{KIND_CHAR, 16'hFFFF, 1'b1, 1'b0, 1'b1}, NO_EV},
        '{CU_COMMA, 1'b0, 1'b1, 2'd1, '{KIND_FEND, 16'h0000, 1'b1, 1'b0, 1'b1}, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{16'h0078, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_CR,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_LF,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_CR,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_LF,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_QUOTE, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_COMMA, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_COMMA, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_LF,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{16'h0062, 1'b1, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_BOM,   1'b1, 1'b1, 2'd1, '{KIND_REND, 16'h0000, 1'b1, 1'b1, 1'b1}, NO_EV},
        '{16'h0061, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_BOM,   1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_CR,    1'b1, 1'b0, 2'd0, NO_EV, NO_EV},
        '{CU_COMMA, 1'b1, 1'b1, 2'd2, '{KIND_FEND, 16'h0000, 1'b1, 1'b0, 1'b0},
                                      '{KIND_REND, 16'h0000, 1'b1, 1'b1, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] code_unit
    logic        s_axis_tlast = 1'b0; // final_unit
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [15:0] char_value, [16] is_header,
                                      // [17] all_fields_empty, [23:18] zero
    logic [1:0]  m_axis_tuser;        // [1:0] event_kind
    logic        m_axis_tlast;        // run_last

    csv_record_tokenizer_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [1:0] tk_quote = QM_OUT;
    logic       tk_field_chars = 1'b0;
    logic       tk_rec_data = 1'b0;
    logic       tk_rec_open = 1'b0;
    logic       tk_after_cr = 1'b0;
    logic       tk_hdr_done = 1'b0;
    logic       tk_first = 1'b1;

    t_event   step_ev[$];
    t_event   ev_due[$];
    t_dir_row row_q[$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  hold_req = 1'b0;
    bit  no_idle = 1'b0;

    function void tk_emit(logic [1:0] kind, logic [15:0] ch, logic empty);
        t_event e;
        if (step_ev.size() < 2) begin
            e.kind  = kind;
            e.ch    = ch;
            e.hdr   = !tk_hdr_done;
            e.empty = empty;
            e.last  = 1'b0;
            step_ev.insert(step_ev.size(), e);
        end
    endfunction

    function void tk_restart();
        tk_quote       = QM_OUT;
        tk_field_chars = 1'b0;
        tk_rec_data    = 1'b0;
        tk_rec_open    = 1'b0;
        tk_after_cr    = 1'b0;
        tk_hdr_done    = 1'b0;
        tk_first       = 1'b1;
    endfunction

    function void tk_end_record();
        tk_emit(KIND_REND, 16'h0000, !(tk_rec_data || tk_field_chars));
        tk_quote       = QM_OUT;
        tk_field_chars = 1'b0;
        tk_rec_data    = 1'b0;
        tk_rec_open    = 1'b0;
        tk_hdr_done    = 1'b1;
    endfunction

    function void tk_outside(logic [15:0] u);
        if (!tk_rec_open && tk_hdr_done && (u == CU_CR || u == CU_LF))
            return;
        tk_rec_open = 1'b1;
        if (u == CU_QUOTE && !tk_field_chars) begin
            tk_quote = QM_IN;
        end else if (u == CU_COMMA) begin
            tk_emit(KIND_FEND, 16'h0000, 1'b0);
            tk_rec_data    = tk_rec_data || tk_field_chars;
            tk_field_chars = 1'b0;
        end else if (u == CU_CR) begin
            tk_end_record();
            tk_after_cr = 1'b1;
        end else if (u == CU_LF) begin
            tk_end_record();
        end else begin
            tk_emit(KIND_CHAR, u, 1'b0);
            tk_field_chars = 1'b1;
        end
    endfunction

    function void tk_any(logic [15:0] u);
        if (tk_quote == QM_PEND) begin
            if (u == CU_QUOTE) begin
                tk_emit(KIND_CHAR, CU_QUOTE, 1'b0);
                tk_field_chars = 1'b1;
                tk_quote       = QM_IN;
            end else begin
                tk_quote = QM_OUT;
                tk_outside(u);
            end
        end else if (tk_quote != QM_OUT) begin
            if (u == CU_QUOTE) begin
                tk_quote = QM_PEND;
            end else begin
                tk_emit(KIND_CHAR, u, 1'b0);
                tk_field_chars = 1'b1;
            end
        end else begin
            tk_outside(u);
        end
    endfunction

    function void tokenize_unit(logic [15:0] u, logic fin);
        logic   first;
        t_event e;
        step_ev.delete();
        first    = tk_first;
        tk_first = 1'b0;
        if (!(first && u == CU_BOM)) begin
            if (tk_after_cr) begin
                tk_after_cr = 1'b0;
                if (u != CU_LF)
                    tk_any(u);
            end else begin
                tk_any(u);
            end
        end
        if (fin) begin
            if (tk_rec_open || !tk_hdr_done)
                tk_end_record();
            tk_restart();
        end
        if (step_ev.size() > 0) begin
            e = step_ev.pop_back();
            e.last = 1'b1;
            step_ev.insert(step_ev.size(), e);
        end
    endfunction

    function automatic logic [15:0] plain_unit();
        logic [15:0] v;
        if ($urandom_range(0, 1))
            v = 16'($urandom_range(0, 65535));
        else
            v = 16'($urandom_range(16'h0020, 16'h007E));
        if (v == CU_QUOTE || v == CU_COMMA || v == CU_CR || v == CU_LF)
            v = 16'h0071;
        return v;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_dir_row    r;
        t_event      e;
        logic [23:0] want;
        logic        moved;
        moved = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved = 1'b1;
            r = (row_q.size() > 0) ? row_q.pop_front() : '0;
            tokenize_unit(s_axis_tdata, s_axis_tlast);
            if (r.typed) begin
                if (r.n > 0)
                    ev_due.insert(ev_due.size(), r.e0);
                if (r.n > 1)
                    ev_due.insert(ev_due.size(), r.e1);
            end else begin
                foreach (step_ev[k])
                    ev_due.insert(ev_due.size(), step_ev[k]);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            if (ev_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected item: kind=%0d data=%h last=%b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                e = ev_due.pop_front();
                want = {6'b0, e.empty, e.hdr, e.ch};
                if (m_axis_tuser !== e.kind || m_axis_tdata !== want
                        || m_axis_tlast !== e.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Mismatch: expected kind=%0d data=%h last=%b,",
                                 e.kind, want, e.last,
                                 " got kind=%0d data=%h last=%b",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : receiver
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    task send_row(input t_dir_row r);
        row_q.insert(row_q.size(), r);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom_range(0, 65535));
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.cu;
        s_axis_tlast  <= r.fin;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_dir_row    row;
        logic [15:0] text[$];
        int          sent;
        int          nrec;
        int          nfld;
        bit          held;
        bit          paused;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[k])
            send_row(DIR_TAB[k]);

        while (sent < RAND_ITEMS) begin
            text.delete();
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(0, 9))
                        0: text.insert(text.size(), CU_QUOTE);
                        1: text.insert(text.size(), CU_COMMA);
                        2: text.insert(text.size(), CU_CR);
                        3: text.insert(text.size(), CU_LF);
                        4: text.insert(text.size(), CU_BOM);
                        default: text.insert(text.size(), 16'($urandom_range(0, 65535)));
                    endcase
                end
            end else begin
                if ($urandom_range(0, 3) == 0)
                    text.insert(text.size(), CU_BOM);
                nrec = $urandom_range(1, 3);
                for (int rec = 0; rec < nrec; rec++) begin
                    if ($urandom_range(0, 5) == 0)
                        text.insert(text.size(), $urandom_range(0, 1) ? CU_CR : CU_LF);
                    nfld = $urandom_range(1, 4);
                    for (int f = 0; f < nfld; f++) begin
                        if (f > 0)
                            text.insert(text.size(), CU_COMMA);
                        case ($urandom_range(0, 3))
                            0: begin
                            end
                            1: repeat ($urandom_range(1, 4)) text.insert(text.size(), plain_unit());
                            2: begin
                                text.insert(text.size(), CU_QUOTE);
                                repeat ($urandom_range(0, 4)) begin
                                    case ($urandom_range(0, 5))
                                        0: text.insert(text.size(), CU_COMMA);
                                        1: text.insert(text.size(), CU_CR);
                                        2: text.insert(text.size(), CU_LF);
                                        3: begin
                                            text.insert(text.size(), CU_QUOTE);
                                            text.insert(text.size(), CU_QUOTE);
                                        end
                                        default: text.insert(text.size(), plain_unit());
                                    endcase
                                end
                                text.insert(text.size(), CU_QUOTE);
                            end
                            default: begin
                                text.insert(text.size(), plain_unit());
                                text.insert(text.size(), CU_QUOTE);
                                text.insert(text.size(), plain_unit());
                            end
                        endcase
                    end
                    if (rec < nrec - 1 || $urandom_range(0, 1)) begin
                        case ($urandom_range(0, 2))
                            0: text.insert(text.size(), CU_CR);
                            1: text.insert(text.size(), CU_LF);
                            default: begin
                                text.insert(text.size(), CU_CR);
                                text.insert(text.size(), CU_LF);
                            end
                        endcase
                    end
                end
            end

            for (int i = 0; i < text.size(); i++) begin
                row     = '0;
                row.cu  = text[i];
                row.fin = (i == text.size() - 1);
                send_row(row);
                sent++;
                if (!held && sent >= 300) begin
                    held     = 1'b1;
                    hold_req = 1'b1;
                end
                if (!paused && sent >= 800) begin
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (ev_due.size() != 0)
                        @(posedge i_clk);
                end
                no_idle = (sent >= RAND_ITEMS - 200);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ev_due.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && ev_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (ev_due.size() != 0)
                $display("%0d expected items never arrived", ev_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
